[rtl/pftbp_pkg.sv]
package pftbp_pkg;

    localparam int unsigned RATE_W  = 32;
    localparam int unsigned CLK_W   = 34;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned TMO_W   = 32;
    localparam int unsigned FLOW_W  = 10;
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 34;

    localparam logic [RATE_W-1:0]  RATE_RESET  = 32'd20000;
    localparam logic [CLK_W-1:0]   CLK_RESET   = 34'h0_8000_0000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1024;
    localparam logic [TMO_W-1:0]   TMO_RESET   = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE           = 2'd0,
        CFG_CLOCK_HZ       = 2'd1,
        CFG_BUCKET_LIMIT   = 2'd2,
        CFG_REFILL_TIMEOUT = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MUL,
        ST_TEST,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADV,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]  last;
        logic [LIMIT_W-1:0] count;
    } t_entry;

endpackage

[rtl/pftbp_if.sv]
interface pftbp_in_if;
    logic                            valid;
    logic                            ready;
    logic [pftbp_pkg::FLOW_W-1:0]    flow_id;
    logic [pftbp_pkg::TIME_W-1:0]    now_ticks;
    modport source (output valid, output flow_id, output now_ticks, input ready);
    modport sink   (input valid, input flow_id, input now_ticks, output ready);
endinterface

interface pftbp_out_if;
    logic                            valid;
    logic                            ready;
    logic                            send;
    logic                            timed_out;
    logic [pftbp_pkg::LIMIT_W-1:0]   tokens_left;
    modport source (output valid, output send, output timed_out, output tokens_left,
                    input ready);
    modport sink   (input valid, input send, input timed_out, input tokens_left,
                    output ready);
endinterface

interface pftbp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pftbp_pkg::CFG_IDX_W-1:0]   index;
    logic [pftbp_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/pftbp_ram.sv]
module pftbp_ram #(
    parameter int unsigned WIDTH = 80,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/per_flow_token_bucket_policer_unit.sv]
// Per-flow token bucket policer.
// The packet channel i_pkt takes one item per packet: a flow number and the
// current timestamp. The result channel o_res gives one item per packet: the
// send decision, the timeout flag and the flow's remaining token count.
// The configuration channel i_cfg writes the token rate (0), clock_hz (1),
// bucket_limit (2) and refill_timeout (3); it is always ready and must only
// be used while no packet is in flight.
// Packets are handled one at a time. A packet naming a flow out of range goes
// straight to its result; one that refills by timeout reads and checks its
// entry; one that adds no tokens also multiplies elapsed time by the rate and
// tests the product. One that adds tokens then runs two 64-bit divisions in a
// shared radix-4 divider and uses a shared 32x32 multiplier three times. The
// next packet can be accepted in the cycle after its result is loaded.
// Bucket state sits in one memory of FLOW_COUNT entries with a registered
// read. After reset the block clears every entry, one per cycle, before the
// first packet is accepted.
// A result waits in an output register while the receiver stalls; the next
// packet is still accepted and processed, and only its write-back waits.
module per_flow_token_bucket_policer_unit #(
    parameter int unsigned FLOW_COUNT = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pftbp_in_if.sink           i_pkt,
    pftbp_out_if.source        o_res,
    pftbp_cfg_if.sink          i_cfg
);

    localparam int unsigned AW = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
    localparam int unsigned EW = $bits(pftbp_pkg::t_entry);
    localparam logic [16:0] FLOW_LAST = 17'(FLOW_COUNT - 1);
    localparam logic [16:0] FLOW_NUM  = 17'(FLOW_COUNT);

    pftbp_pkg::t_state r_state;
    pftbp_pkg::t_state n_state;

    logic [pftbp_pkg::RATE_W-1:0]  r_rate;
    logic [pftbp_pkg::CLK_W-1:0]   r_clk_hz;
    logic [pftbp_pkg::LIMIT_W-1:0] r_limit;
    logic [pftbp_pkg::TMO_W-1:0]   r_timeout;

    logic [16:0]       r_clr_idx;
    logic [9:0]        r_flow;
    logic [63:0]       r_now;
    logic              r_oob;
    logic [15:0]       r_count;
    logic [63:0]       r_last;
    logic [63:0]       r_elapsed;
    logic              r_tmo;
    logic [63:0]       r_prod;
    logic [63:0]       r_add;
    logic [33:0]       r_q2;
    logic [63:0]       r_p0;
    logic [31:0]       r_p1;

    logic [34:0]       r_rem;
    logic [63:0]       r_quo;
    logic [33:0]       r_div;
    logic [4:0]        r_step;
    logic              r_phase;
    logic [34:0]       n_rem;
    logic [63:0]       n_quo;

    logic              r_out_valid;
    logic              r_out_send;
    logic              r_out_tmo;
    logic [15:0]       r_out_left;

    logic [16:0]       w_flow_ext;
    logic              w_in_oob;
    logic              w_out_free;
    logic [31:0]       w_mul_a;
    logic [31:0]       w_mul_b;
    logic [63:0]       w_mul;
    logic [31:0]       w_mid;
    logic [15:0]       w_refill_count;
    logic [15:0]       w_final_count;
    logic              w_final_send;

    logic              w_pkt_ready;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    pftbp_pkg::t_entry w_wdata;
    logic [AW-1:0]     w_raddr;
    pftbp_pkg::t_entry w_rdata;
    logic [EW-1:0]     w_rdata_raw;

    pftbp_ram #(
        .WIDTH (EW),
        .DEPTH (FLOW_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata    = w_rdata_raw;
    assign w_flow_ext = 17'(i_pkt.flow_id);
    assign w_in_oob   = (w_flow_ext >= FLOW_NUM);
    assign w_out_free = !r_out_valid || o_res.ready;

    always_comb begin
        unique case (r_state)
            pftbp_pkg::ST_MUL: begin
                w_mul_a = r_elapsed[31:0];
                w_mul_b = r_rate;
            end
            pftbp_pkg::ST_MUL_HI: begin
                w_mul_a = r_add[63:32];
                w_mul_b = r_q2[31:0];
            end
            default: begin
                w_mul_a = r_add[31:0];
                w_mul_b = r_q2[31:0];
            end
        endcase
    end

    assign w_mul = 64'(w_mul_a) * 64'(w_mul_b);

    always_comb begin
        logic [34:0] v_rem;
        logic [63:0] v_quo;
        v_rem = r_rem;
        v_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            v_rem = {v_rem[33:0], v_quo[63]};
            v_quo = {v_quo[62:0], 1'b0};
            if (v_rem >= {1'b0, r_div}) begin
                v_rem    = v_rem - {1'b0, r_div};
                v_quo[0] = 1'b1;
            end
        end
        n_rem = v_rem;
        n_quo = v_quo;
    end

    assign w_mid = r_p1 + (r_q2[32] ? r_add[31:0] : 32'd0)
                 + (r_q2[33] ? {r_add[30:0], 1'b0} : 32'd0);

    always_comb begin
        if (r_count >= r_limit || r_add >= {48'd0, r_limit - r_count}) begin
            w_refill_count = r_limit;
        end else begin
            w_refill_count = r_count + r_add[15:0];
        end
    end

    assign w_final_send  = !r_oob && (r_count != 16'd0);
    assign w_final_count = w_final_send ? r_count - 16'd1 : r_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pftbp_pkg::ST_CLEAR: begin
                if (r_clr_idx == FLOW_LAST) begin
                    n_state = pftbp_pkg::ST_IDLE;
                end
            end
            pftbp_pkg::ST_IDLE: begin
                if (i_pkt.valid) begin
                    n_state = w_in_oob ? pftbp_pkg::ST_FINAL : pftbp_pkg::ST_READ;
                end
            end
            pftbp_pkg::ST_READ:  n_state = pftbp_pkg::ST_CHECK;
            pftbp_pkg::ST_CHECK: begin
                if (r_elapsed >= {32'd0, r_timeout}) begin
                    n_state = pftbp_pkg::ST_FINAL;
                end else begin
                    n_state = pftbp_pkg::ST_MUL;
                end
            end
            pftbp_pkg::ST_MUL:   n_state = pftbp_pkg::ST_TEST;
            pftbp_pkg::ST_TEST: begin
                if (r_clk_hz != '0 && r_prod > {30'd0, r_clk_hz}) begin
                    n_state = pftbp_pkg::ST_DIV;
                end else begin
                    n_state = pftbp_pkg::ST_FINAL;
                end
            end
            pftbp_pkg::ST_DIV: begin
                if (r_step == 5'd31 && r_phase) begin
                    n_state = pftbp_pkg::ST_MUL_LO;
                end
            end
            pftbp_pkg::ST_MUL_LO: n_state = pftbp_pkg::ST_MUL_HI;
            pftbp_pkg::ST_MUL_HI: n_state = pftbp_pkg::ST_ADV;
            pftbp_pkg::ST_ADV:    n_state = pftbp_pkg::ST_FINAL;
            pftbp_pkg::ST_FINAL: begin
                if (w_out_free) begin
                    n_state = pftbp_pkg::ST_IDLE;
                end
            end
            default: n_state = pftbp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_pkt_ready = 1'b0;
        w_we        = 1'b0;
        w_waddr     = AW'(r_flow);
        w_wdata     = '{last: r_last, count: w_final_count};
        w_raddr     = w_flow_ext[AW-1:0];
        unique case (r_state)
            pftbp_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_idx[AW-1:0];
                w_wdata = '0;
            end
            pftbp_pkg::ST_IDLE: begin
                w_pkt_ready = 1'b1;
            end
            pftbp_pkg::ST_FINAL: begin
                w_we = w_out_free && !r_oob;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign i_pkt.ready = w_pkt_ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pftbp_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_rate      <= pftbp_pkg::RATE_RESET;
            r_clk_hz    <= pftbp_pkg::CLK_RESET;
            r_limit     <= pftbp_pkg::LIMIT_RESET;
            r_timeout   <= pftbp_pkg::TMO_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == pftbp_pkg::ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 17'd1;
            end
            if (i_cfg.valid) begin
                unique case (pftbp_pkg::t_cfg_idx'(i_cfg.index))
                    pftbp_pkg::CFG_RATE:           r_rate    <= i_cfg.data[31:0];
                    pftbp_pkg::CFG_CLOCK_HZ:       r_clk_hz  <= i_cfg.data;
                    pftbp_pkg::CFG_BUCKET_LIMIT:   r_limit   <= i_cfg.data[15:0];
                    pftbp_pkg::CFG_REFILL_TIMEOUT: r_timeout <= i_cfg.data[31:0];
                    default: r_rate <= r_rate;
                endcase
            end
            if (r_state == pftbp_pkg::ST_FINAL && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pftbp_pkg::ST_IDLE: begin
                r_flow  <= i_pkt.flow_id;
                r_now   <= i_pkt.now_ticks;
                r_oob   <= w_in_oob;
                r_count <= '0;
                r_tmo   <= 1'b0;
            end
            pftbp_pkg::ST_READ: begin
                r_count   <= w_rdata.count;
                r_last    <= w_rdata.last;
                r_elapsed <= r_now - w_rdata.last;
            end
            pftbp_pkg::ST_CHECK: begin
                if (r_elapsed >= {32'd0, r_timeout}) begin
                    r_count <= r_limit;
                    r_last  <= r_now;
                    r_tmo   <= 1'b1;
                end
            end
            pftbp_pkg::ST_MUL: begin
                r_prod <= w_mul;
            end
            pftbp_pkg::ST_TEST: begin
                r_rem   <= '0;
                r_quo   <= r_prod;
                r_div   <= r_clk_hz;
                r_step  <= '0;
                r_phase <= 1'b0;
            end
            pftbp_pkg::ST_DIV: begin
                r_step <= r_step + 5'd1;
                if (r_step == 5'd31 && !r_phase) begin
                    r_add   <= n_quo;
                    r_rem   <= '0;
                    r_quo   <= {30'd0, r_clk_hz};
                    r_div   <= {2'd0, r_rate};
                    r_phase <= 1'b1;
                end else begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    if (r_step == 5'd31) begin
                        r_q2 <= n_quo[33:0];
                    end
                end
            end
            pftbp_pkg::ST_MUL_LO: begin
                r_p0 <= w_mul;
            end
            pftbp_pkg::ST_MUL_HI: begin
                r_p1 <= w_mul[31:0];
            end
            pftbp_pkg::ST_ADV: begin
                r_last  <= r_last + r_p0 + {w_mid, 32'd0};
                r_count <= w_refill_count;
            end
            pftbp_pkg::ST_FINAL: begin
                if (w_out_free) begin
                    r_out_send <= w_final_send;
                    r_out_tmo  <= r_tmo;
                    r_out_left <= w_final_count;
                end
            end
            default: begin
                r_tmo <= r_tmo;
            end
        endcase
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.send        = r_out_send;
    assign o_res.timed_out   = r_out_tmo;
    assign o_res.tokens_left = r_out_left;

endmodule

[tb/tb_per_flow_token_bucket_policer_unit.sv]
`timescale 1ns / 1ps

module tb_per_flow_token_bucket_policer_unit;

    localparam int unsigned FLOWS = 1024;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned PHASE_ITEMS = 122;
    localparam int unsigned NUM_PHASES = 8;

    typedef struct packed {
        logic                          send;
        logic                          timed_out;
        logic [pftbp_pkg::LIMIT_W-1:0] tokens_left;
    } t_verdict;

    typedef struct packed {
        logic [pftbp_pkg::FLOW_W-1:0] flow;
        logic [pftbp_pkg::TIME_W-1:0] now;
        logic                         known;
        t_verdict                     verdict;
    } t_dir_row;

    typedef struct packed {
        logic [pftbp_pkg::RATE_W-1:0]  rate;
        logic [pftbp_pkg::CLK_W-1:0]   hz;
        logic [pftbp_pkg::LIMIT_W-1:0] limit;
        logic [pftbp_pkg::TMO_W-1:0]   timeout;
        logic [31:0]                   step;
        logic                          no_idle;
    } t_phase;

    logic i_clk;
    logic i_rst_n;

    pftbp_in_if  pkt_if();
    pftbp_out_if res_if();
    pftbp_cfg_if cfg_if();

    per_flow_token_bucket_policer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    logic [pftbp_pkg::RATE_W-1:0]  pol_rate;
    logic [pftbp_pkg::CLK_W-1:0]   pol_hz;
    logic [pftbp_pkg::LIMIT_W-1:0] pol_limit;
    logic [pftbp_pkg::TMO_W-1:0]   pol_timeout;
    logic [pftbp_pkg::LIMIT_W-1:0] bucket_tokens [FLOWS];
    logic [pftbp_pkg::TIME_W-1:0]  bucket_stamp [FLOWS];

    t_verdict    verdict_q[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    logic        no_idle = 1'b0;
    logic        long_hold_req = 1'b0;
    int unsigned hold_left;
    logic [pftbp_pkg::TIME_W-1:0] clock_now;

    t_dir_row dir_rows [12] = '{
        '{10'd0,    64'd0,                  1'b1, '{1'b0, 1'b0, 16'd0}},
        '{10'd1023, 64'h8000_0000,          1'b1, '{1'b1, 1'b1, 16'd1023}},
        '{10'd1023, 64'd0,                  1'b1, '{1'b1, 1'b1, 16'd1023}},
        '{10'd5,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 1'b1, 16'd1023}},
        '{10'd5,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 1'b0, 16'd1022}},
        '{10'd1023, 64'd107374,             1'b0, '0},
        '{10'd1023, 64'd300000,             1'b0, '0},
        '{10'd1023, 64'd5000000,            1'b0, '0},
        '{10'd512,  64'h7FFF_FFFF,          1'b0, '0},
        '{10'd2,    64'h5555_5555_5555_5555, 1'b0, '0},
        '{10'd2,    64'h5555_5555_5557_0000, 1'b0, '0},
        '{10'd3,    64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0}
    };

    t_phase phases [NUM_PHASES] = '{
        '{32'd20000,      34'h0_8000_0000, 16'd1024,  32'h8000_0000, 32'd300000, 1'b0},
        '{32'd1000,       34'd100000,      16'd8,     32'd100000,    32'd200,    1'b0},
        '{32'hFFFF_FFFF,  34'h3_FFFF_FFFF, 16'd65535, 32'hFFFF_FFFF, 32'd10,     1'b1},
        '{32'd7,          34'd1,           16'd0,     32'd1,         32'd3,      1'b0},
        '{32'd0,          34'd0,           16'd3,     32'd5000,      32'd2000,   1'b0},
        '{32'd5000000,    34'd1000,        16'd100,   32'd1000,      32'd5,      1'b0},
        '{32'd1000,       34'd100000,      16'd65535, 32'hFFFF_FFFF, 32'd20000,  1'b0},
        '{32'd1000,       34'd100000,      16'd4,     32'hFFFF_FFFF, 32'd200,    1'b0}
    };

    function automatic t_verdict police_packet(input logic [pftbp_pkg::FLOW_W-1:0] flow,
                                               input logic [pftbp_pkg::TIME_W-1:0] now);
        logic [63:0] elapsed;
        logic [63:0] product;
        logic [63:0] added;
        logic [63:0] count;
        logic [63:0] lim;
        t_verdict    v;
        lim = {48'b0, pol_limit};
        count = {48'b0, bucket_tokens[flow]};
        elapsed = now - bucket_stamp[flow];
        v.timed_out = 1'b0;
        if (elapsed < {32'b0, pol_timeout}) begin
            product = elapsed * {32'b0, pol_rate};
            if (pol_hz != '0 && product > {30'b0, pol_hz}) begin
                added = product / {30'b0, pol_hz};
                bucket_stamp[flow] = bucket_stamp[flow]
                    + added * ({30'b0, pol_hz} / {32'b0, pol_rate});
                if (count >= lim || added >= lim - count) begin
                    count = lim;
                end else begin
                    count = count + added;
                end
            end
        end else begin
            count = lim;
            bucket_stamp[flow] = now;
            v.timed_out = 1'b1;
        end
        v.send = (count >= 1);
        if (v.send) begin
            count = count - 1;
        end
        bucket_tokens[flow] = count[15:0];
        v.tokens_left = count[15:0];
        return v;
    endfunction

    always begin
        #5 i_clk = 1'b0;
        #5 i_clk = 1'b1;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic hold_taken;
        hold_taken = 1'b0;
        hold_left = 0;
        res_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = 400;
            end else if (hold_left == 0 && !no_idle && $urandom_range(0, 99) < 25) begin
                hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 3);
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                res_if.ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (verdict_q.size() == 0) begin
                $error("result item with nothing expected");
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                if (res_if.send !== want.send) begin
                    $error("send: expected %0d, got %0d", want.send, res_if.send);
                    fail_count++;
                end
                if (res_if.timed_out !== want.timed_out) begin
                    $error("timed_out: expected %0d, got %0d",
                           want.timed_out, res_if.timed_out);
                    fail_count++;
                end
                if (res_if.tokens_left !== want.tokens_left) begin
                    $error("tokens_left: expected %0d, got %0d",
                           want.tokens_left, res_if.tokens_left);
                    fail_count++;
                end
            end
        end
    end

    task automatic offer_packet(input logic [pftbp_pkg::FLOW_W-1:0] flow,
                                input logic [pftbp_pkg::TIME_W-1:0] now,
                                input logic known, input t_verdict typed);
        int unsigned gap;
        t_verdict    v;
        gap = 0;
        if (!no_idle) begin
            case ($urandom_range(0, 19))
                0: gap = $urandom_range(10, 40);
                1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
                default: gap = 0;
            endcase
        end
        if (gap > 0) begin
            pkt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pkt_if.valid <= 1'b1;
        pkt_if.flow_id <= flow;
        pkt_if.now_ticks <= now;
        do @(posedge i_clk); while (!pkt_if.ready);
        v = police_packet(flow, now);
        verdict_q.push_back(known ? typed : v);
    endtask

    task automatic wait_drained();
        pkt_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_register(input pftbp_pkg::t_cfg_idx idx,
                                  input logic [pftbp_pkg::CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            pftbp_pkg::CFG_RATE:           pol_rate = value[pftbp_pkg::RATE_W-1:0];
            pftbp_pkg::CFG_CLOCK_HZ:       pol_hz = value[pftbp_pkg::CLK_W-1:0];
            pftbp_pkg::CFG_BUCKET_LIMIT:   pol_limit = value[pftbp_pkg::LIMIT_W-1:0];
            pftbp_pkg::CFG_REFILL_TIMEOUT: pol_timeout = value[pftbp_pkg::TMO_W-1:0];
            default: ;
        endcase
    endtask

    initial begin
        logic [pftbp_pkg::FLOW_W-1:0] flow;
        logic [pftbp_pkg::TIME_W-1:0] now;
        int unsigned                  pick;
        int unsigned                  pick_flow;
        pkt_if.valid = 1'b0;
        pkt_if.flow_id = '0;
        pkt_if.now_ticks = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = pftbp_pkg::CFG_RATE;
        cfg_if.data = '0;
        clock_now = '0;
        pol_rate = pftbp_pkg::RATE_RESET;
        pol_hz = pftbp_pkg::CLK_RESET;
        pol_limit = pftbp_pkg::LIMIT_RESET;
        pol_timeout = pftbp_pkg::TMO_RESET;
        for (int i = 0; i < FLOWS; i++) begin
            bucket_tokens[i] = '0;
            bucket_stamp[i] = '0;
        end
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            offer_packet(dir_rows[i].flow, dir_rows[i].now, dir_rows[i].known,
                         dir_rows[i].verdict);
        end
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_register(pftbp_pkg::CFG_RATE, {2'b0, phases[p].rate});
            write_register(pftbp_pkg::CFG_CLOCK_HZ, phases[p].hz);
            write_register(pftbp_pkg::CFG_BUCKET_LIMIT, {18'b0, phases[p].limit});
            write_register(pftbp_pkg::CFG_REFILL_TIMEOUT, {2'b0, phases[p].timeout});
            cfg_if.valid <= 1'b0;
            no_idle = phases[p].no_idle;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 40) begin
                    long_hold_req = 1'b1;
                end
                pick_flow = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 1023);
                flow = pick_flow[pftbp_pkg::FLOW_W-1:0];
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    clock_now = clock_now + $urandom_range(0, phases[p].step);
                    now = clock_now;
                end else if (pick < 88) begin
                    clock_now = clock_now + ({$urandom, $urandom} >> $urandom_range(20, 40));
                    now = clock_now;
                end else if (pick < 94) begin
                    clock_now = {$urandom, $urandom};
                    now = clock_now;
                end else begin
                    now = clock_now - $urandom_range(1, 1000);
                end
                offer_packet(flow, now, 1'b0, '0);
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
